>>> hdl/pjsp_pkg.sv
package pjsp_pkg;

    // Stream framing constants.
    localparam int MARK_LEN      = 34;
    localparam int HEADER_BYTES  = 290;
    localparam int FOOTER_BYTES  = 7;
    localparam int WIDTH_OFFSET  = 0;
    localparam int HEIGHT_OFFSET = 2;

    localparam int MARK_POS_W = 6;
    localparam int HDR_POS_W  = 9;
    localparam int FOOTER_W   = 3;
    localparam int LIMIT_W    = 25;
    localparam int COUNT_W    = 25;

    // Bytes of the copy count pattern.
    localparam logic [7:0] COPY_PAT_0 = 8'h02;
    localparam logic [7:0] COPY_PAT_1 = 8'h00;
    localparam logic [7:0] COPY_PAT_2 = 8'h09;

    // Operation codes.
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PREPARE = 1'b1;

    // Event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PIXEL    = 3'd1;
    localparam logic [2:0] EV_HEADER   = 3'd2;
    localparam logic [2:0] EV_IMG_DONE = 3'd3;
    localparam logic [2:0] EV_JOB_DONE = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    // Stage codes as reported on the result.
    localparam logic [2:0] SC_SCAN    = 3'd0;
    localparam logic [2:0] SC_HEADER  = 3'd1;
    localparam logic [2:0] SC_PAYLOAD = 3'd2;
    localparam logic [2:0] SC_FOOTER  = 3'd3;
    localparam logic [2:0] SC_DONE    = 3'd4;
    localparam logic [2:0] SC_ERROR   = 3'd5;

    // Register index of the image size limit.
    localparam logic REG_MAX_IMAGE = 1'b0;
    localparam logic [LIMIT_W-1:0] MAX_IMAGE_RESET = 25'd4194304;

    typedef enum logic [5:0] {
        ST_SCAN    = 6'b000001,
        ST_HEADER  = 6'b000010,
        ST_PAYLOAD = 6'b000100,
        ST_FOOTER  = 6'b001000,
        ST_DONE    = 6'b010000,
        ST_ERROR   = 6'b100000
    } t_stage;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  pixel_value;
        logic [23:0] pixel_index;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  copy_count;
        logic [2:0]  stage;
    } t_out_res;

    // Characters of the job marker, CR LF at the end.
    function automatic logic [7:0] marker_char(input logic [MARK_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            6'd0:  c = "@";
            6'd1:  c = "P";
            6'd2:  c = "J";
            6'd3:  c = "L";
            6'd4:  c = " ";
            6'd5:  c = "E";
            6'd6:  c = "N";
            6'd7:  c = "T";
            6'd8:  c = "E";
            6'd9:  c = "R";
            6'd10: c = " ";
            6'd11: c = "L";
            6'd12: c = "A";
            6'd13: c = "N";
            6'd14: c = "G";
            6'd15: c = "U";
            6'd16: c = "A";
            6'd17: c = "G";
            6'd18: c = "E";
            6'd19: c = "=";
            6'd20: c = "S";
            6'd21: c = "O";
            6'd22: c = "N";
            6'd23: c = "Y";
            6'd24: c = "-";
            6'd25: c = "P";
            6'd26: c = "D";
            6'd27: c = "L";
            6'd28: c = "-";
            6'd29: c = "D";
            6'd30: c = "S";
            6'd31: c = "2";
            6'd32: c = 8'd13;
            6'd33: c = 8'd10;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Reported code of a stage.
    function automatic logic [2:0] stage_code(input t_stage s);
        logic [2:0] c;
        unique case (s)
            ST_SCAN:    c = SC_SCAN;
            ST_HEADER:  c = SC_HEADER;
            ST_PAYLOAD: c = SC_PAYLOAD;
            ST_FOOTER:  c = SC_FOOTER;
            ST_DONE:    c = SC_DONE;
            ST_ERROR:   c = SC_ERROR;
            default:    c = SC_ERROR;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/print_job_stream_parser.sv
// Print job stream parser.
//
// Requests enter on the i_in_* channel, one stream byte or a prepare
// operation each, and every request gives exactly one result on the o_out_*
// channel. Both channels use valid and ready.
// The parser hunts for the job marker, collects the binary header, checks
// the image size against the limit register, passes out the pixel bytes with
// their indexes and then skips the footer.
// The result is registered: a request accepted at one edge has its result valid
// after that edge. One request is taken in every cycle unless a held result
// stalls it; all work for a byte is a table compare, counter updates and one
// 16 by 16 multiply, done between the request and the result register.
// When the receiver stalls, the result is held and o_in_ready stays high only
// if the held result is taken in the same cycle, so nothing is lost.
// Reset clears the parse state, sets the limit register to 4194304 and
// empties the result register. The limit is to be written over the APB port
// at address 0 while the block is idle; the block itself does not enforce it.
module print_job_stream_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  pjsp_pkg::t_in_req        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output pjsp_pkg::t_out_res       o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    pjsp_pkg::t_stage                      r_stage, n_stage;
    logic [pjsp_pkg::MARK_POS_W-1:0]       r_mpos, n_mpos;
    logic [pjsp_pkg::HDR_POS_W-1:0]        r_hpos, n_hpos;
    logic [31:0]                           r_window, n_window;
    logic [15:0]                           r_width, n_width;
    logic [15:0]                           r_height, n_height;
    logic [7:0]                            r_copies, n_copies;
    logic                                  r_copies_found, n_copies_found;
    logic [pjsp_pkg::COUNT_W-1:0]          r_total, n_total;
    logic [pjsp_pkg::COUNT_W-1:0]          r_pix, n_pix;
    logic [pjsp_pkg::FOOTER_W-1:0]         r_foot, n_foot;
    logic [pjsp_pkg::LIMIT_W-1:0]          r_max;
    logic                                  r_out_valid;
    pjsp_pkg::t_out_res                    r_out;
    pjsp_pkg::t_out_res                    n_res;

    logic                                  in_acc;
    logic                                  cfg_wr;
    logic [7:0]                            b;
    logic [pjsp_pkg::MARK_POS_W-1:0]       mpos_eff;
    logic [15:0]                           hb_width;
    logic [15:0]                           hb_height;
    logic [31:0]                           prod;
    logic [pjsp_pkg::HDR_POS_W:0]          hpos_inc;
    logic                                  hdr_last;
    logic                                  hdr_bad;
    logic                                  copy_hit;
    logic [pjsp_pkg::COUNT_W-1:0]          pix_inc;
    logic [pjsp_pkg::FOOTER_W-1:0]         foot_dec;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign b          = i_in_data.data_byte;

    // Configuration port: always ready, one register at address zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == pjsp_pkg::REG_MAX_IMAGE)
                  ? {{(32-pjsp_pkg::LIMIT_W){1'b0}}, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= pjsp_pkg::MAX_IMAGE_RESET;
        end else if (cfg_wr && paddr == pjsp_pkg::REG_MAX_IMAGE) begin
            r_max <= pwdata[pjsp_pkg::LIMIT_W-1:0];
        end
    end

    // Header field capture for the current byte, big-endian dimensions.
    always_comb begin
        hb_width  = r_width;
        hb_height = r_height;
        if (r_hpos == pjsp_pkg::HDR_POS_W'(pjsp_pkg::WIDTH_OFFSET)) begin
            hb_width[15:8] = b;
        end
        if (r_hpos == pjsp_pkg::HDR_POS_W'(pjsp_pkg::WIDTH_OFFSET + 1)) begin
            hb_width[7:0] = b;
        end
        if (r_hpos == pjsp_pkg::HDR_POS_W'(pjsp_pkg::HEIGHT_OFFSET)) begin
            hb_height[15:8] = b;
        end
        if (r_hpos == pjsp_pkg::HDR_POS_W'(pjsp_pkg::HEIGHT_OFFSET + 1)) begin
            hb_height[7:0] = b;
        end
    end

    // Size check on the final header byte.
    assign prod     = hb_width * hb_height;
    assign hpos_inc = {1'b0, r_hpos} + 1'b1;
    assign hdr_last = hpos_inc >= (pjsp_pkg::HDR_POS_W+1)'(pjsp_pkg::HEADER_BYTES);
    assign hdr_bad  = (hb_width == 16'd0) || (hb_height == 16'd0)
                   || (prod > {{(32-pjsp_pkg::LIMIT_W){1'b0}}, r_max});

    // Copy pattern: the three bytes before the one four places on.
    assign copy_hit = !r_copies_found && (r_hpos >= pjsp_pkg::HDR_POS_W'(4))
                   && (r_window[31:8] == {pjsp_pkg::COPY_PAT_0, pjsp_pkg::COPY_PAT_1,
                                          pjsp_pkg::COPY_PAT_2});

    assign mpos_eff = (r_mpos >= pjsp_pkg::MARK_POS_W'(pjsp_pkg::MARK_LEN))
                    ? '0 : r_mpos;
    assign pix_inc  = r_pix + 1'b1;
    assign foot_dec = (r_foot != '0) ? r_foot - 1'b1 : r_foot;

    // Next parse state and the result of one request.
    always_comb begin
        n_stage        = r_stage;
        n_mpos         = r_mpos;
        n_hpos         = r_hpos;
        n_window       = r_window;
        n_width        = r_width;
        n_height       = r_height;
        n_copies       = r_copies;
        n_copies_found = r_copies_found;
        n_total        = r_total;
        n_pix          = r_pix;
        n_foot         = r_foot;
        n_res          = '0;
        n_res.event_res = pjsp_pkg::EV_NONE;

        if (i_in_data.operation == pjsp_pkg::OP_PREPARE) begin
            n_stage        = pjsp_pkg::ST_SCAN;
            n_mpos         = '0;
            n_hpos         = '0;
            n_window       = '0;
            n_width        = '0;
            n_height       = '0;
            n_copies       = 8'd1;
            n_copies_found = 1'b0;
            n_total        = '0;
            n_pix          = '0;
            n_foot         = '0;
        end else begin
            unique case (r_stage)
                pjsp_pkg::ST_SCAN: begin
                    if (b == pjsp_pkg::marker_char(mpos_eff)) begin
                        if (mpos_eff == pjsp_pkg::MARK_POS_W'(pjsp_pkg::MARK_LEN - 1)) begin
                            n_mpos         = '0;
                            n_stage        = pjsp_pkg::ST_HEADER;
                            n_hpos         = '0;
                            n_window       = '0;
                            n_width        = '0;
                            n_height       = '0;
                            n_copies       = 8'd1;
                            n_copies_found = 1'b0;
                        end else begin
                            n_mpos = mpos_eff + 1'b1;
                        end
                    end else if (b == pjsp_pkg::marker_char('0)) begin
                        n_mpos = pjsp_pkg::MARK_POS_W'(1);
                    end else begin
                        n_mpos = '0;
                    end
                end
                pjsp_pkg::ST_HEADER: begin
                    n_width  = hb_width;
                    n_height = hb_height;
                    if (copy_hit) begin
                        n_copies_found = 1'b1;
                        n_copies       = (b != 8'd0) ? b : 8'd1;
                    end
                    n_window = {r_window[23:0], b};
                    n_hpos   = hpos_inc[pjsp_pkg::HDR_POS_W-1:0];
                    if (hdr_last) begin
                        if (hdr_bad) begin
                            n_stage         = pjsp_pkg::ST_ERROR;
                            n_res.event_res = pjsp_pkg::EV_ERROR;
                        end else begin
                            n_total         = prod[pjsp_pkg::COUNT_W-1:0];
                            n_pix           = '0;
                            n_foot          = pjsp_pkg::FOOTER_W'(pjsp_pkg::FOOTER_BYTES);
                            n_stage         = pjsp_pkg::ST_PAYLOAD;
                            n_res.event_res = pjsp_pkg::EV_HEADER;
                        end
                    end
                end
                pjsp_pkg::ST_PAYLOAD: begin
                    n_res.event_res   = pjsp_pkg::EV_PIXEL;
                    n_res.pixel_value = b;
                    n_res.pixel_index = r_pix[23:0];
                    n_pix             = pix_inc;
                    if (pix_inc >= r_total) begin
                        n_stage = pjsp_pkg::ST_FOOTER;
                        n_foot  = pjsp_pkg::FOOTER_W'(pjsp_pkg::FOOTER_BYTES);
                    end
                end
                pjsp_pkg::ST_FOOTER: begin
                    n_foot = foot_dec;
                    if (foot_dec == '0) begin
                        n_stage         = pjsp_pkg::ST_DONE;
                        n_res.event_res = pjsp_pkg::EV_JOB_DONE;
                    end else begin
                        n_res.event_res = pjsp_pkg::EV_IMG_DONE;
                    end
                end
                default: begin
                    // Complete and error stages drop the byte.
                end
            endcase
        end

        n_res.image_width  = n_width;
        n_res.image_height = n_height;
        n_res.copy_count   = n_copies;
        n_res.stage        = pjsp_pkg::stage_code(n_stage);
    end

    // Parse state registers, advanced on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage        <= pjsp_pkg::ST_SCAN;
            r_mpos         <= '0;
            r_hpos         <= '0;
            r_window       <= '0;
            r_width        <= '0;
            r_height       <= '0;
            r_copies       <= 8'd1;
            r_copies_found <= 1'b0;
            r_total        <= '0;
            r_pix          <= '0;
            r_foot         <= '0;
        end else if (in_acc) begin
            r_stage        <= n_stage;
            r_mpos         <= n_mpos;
            r_hpos         <= n_hpos;
            r_window       <= n_window;
            r_width        <= n_width;
            r_height       <= n_height;
            r_copies       <= n_copies;
            r_copies_found <= n_copies_found;
            r_total        <= n_total;
            r_pix          <= n_pix;
            r_foot         <= n_foot;
        end
    end

    // Result register: filled on a request, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_res;
        end
    end

    // The pixel count stays below the image size throughout the payload.
    a_pix_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == pjsp_pkg::ST_PAYLOAD) |-> (r_pix < r_total))
        else $error("pixel count reached image size inside payload");

    // An accepted header always carries non-zero dimensions and copies.
    a_header_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == pjsp_pkg::EV_HEADER) |->
        (o_out_data.image_width != 16'd0 && o_out_data.image_height != 16'd0
         && o_out_data.copy_count != 8'd0
         && o_out_data.stage == pjsp_pkg::SC_PAYLOAD))
        else $error("header accepted with bad fields");

    // Pixel results only come out of the payload, ending in payload or footer.
    a_pixel_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == pjsp_pkg::EV_PIXEL) |->
        (o_out_data.stage == pjsp_pkg::SC_PAYLOAD
         || o_out_data.stage == pjsp_pkg::SC_FOOTER))
        else $error("pixel result outside payload");

endmodule

>>> sim/pjsp_checker.sv
module pjsp_checker #(
    parameter logic [8*pjsp_pkg::MARK_LEN-1:0] JOB_MARKER = '0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  pjsp_pkg::t_in_req  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pjsp_pkg::t_out_res i_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_headers,
    output int                 o_errors,
    output int                 o_jobs,
    output int                 o_pixels
);
    timeunit 1ns;
    timeprecision 1ps;
    import pjsp_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Shadow of the parser state and of the size limit register.
    logic [2:0]         job_stage;
    logic [5:0]         mark_pos;
    logic [8:0]         hdr_pos;
    logic [31:0]        hdr_window;
    logic [15:0]        job_width;
    logic [15:0]        job_height;
    logic [7:0]         job_copies;
    logic               copies_seen;
    logic [COUNT_W-1:0] pixel_total;
    logic [COUNT_W-1:0] pixel_count;
    logic [2:0]         footer_count;
    logic [LIMIT_W-1:0] size_limit;

    // Results predicted for accepted requests, oldest first.
    t_out_res expected_results[$];
    t_out_res want;

    function automatic logic [7:0] mark_at(input int i);
        return JOB_MARKER[(MARK_LEN-1-i)*8 +: 8];
    endfunction

    task automatic clear_job();
        job_stage    = SC_SCAN;
        mark_pos     = '0;
        hdr_pos      = '0;
        hdr_window   = '0;
        job_width    = '0;
        job_height   = '0;
        job_copies   = 8'd1;
        copies_seen  = 1'b0;
        pixel_total  = '0;
        pixel_count  = '0;
        footer_count = '0;
    endtask

    // Advances the shadow state by one request and gives the result it causes.
    task automatic parse_request(input t_in_req rq, output t_out_res rs);
        logic [2:0]  ev;
        logic [7:0]  pix;
        logic [23:0] idx;
        logic [7:0]  b;
        logic [5:0]  pos;
        logic [8:0]  p;
        logic [31:0] area;
        ev  = EV_NONE;
        pix = '0;
        idx = '0;
        b   = rq.data_byte;
        if (rq.operation == OP_PREPARE) begin
            clear_job();
        end else begin
            case (job_stage)
                SC_SCAN: begin
                    pos = (mark_pos >= MARK_LEN) ? 6'd0 : mark_pos;
                    if (b == mark_at(pos)) begin
                        pos = pos + 6'd1;
                        if (pos == MARK_LEN) begin
                            pos         = '0;
                            job_stage   = SC_HEADER;
                            hdr_pos     = '0;
                            hdr_window  = '0;
                            job_width   = '0;
                            job_height  = '0;
                            job_copies  = 8'd1;
                            copies_seen = 1'b0;
                        end
                    end else begin
                        // A mismatching '@' may itself start the marker.
                        pos = (b == mark_at(0)) ? 6'd1 : 6'd0;
                    end
                    mark_pos = pos;
                end
                SC_HEADER: begin
                    p = hdr_pos;
                    if (p == WIDTH_OFFSET)      job_width[15:8]  = b;
                    if (p == WIDTH_OFFSET + 1)  job_width[7:0]   = b;
                    if (p == HEIGHT_OFFSET)     job_height[15:8] = b;
                    if (p == HEIGHT_OFFSET + 1) job_height[7:0]  = b;
                    // The copy count sits four bytes after the first pattern.
                    if (!copies_seen && p >= 4 &&
                        hdr_window[31:8] == {COPY_PAT_0, COPY_PAT_1, COPY_PAT_2}) begin
                        copies_seen = 1'b1;
                        job_copies  = (b >= 8'd1) ? b : 8'd1;
                    end
                    hdr_window = {hdr_window[23:0], b};
                    hdr_pos    = p + 9'd1;
                    if (p + 1 >= HEADER_BYTES) begin
                        area = 32'(job_width) * 32'(job_height);
                        if (job_width == 0 || job_height == 0 || area > 32'(size_limit)) begin
                            job_stage = SC_ERROR;
                            ev        = EV_ERROR;
                        end else begin
                            pixel_total  = area[COUNT_W-1:0];
                            pixel_count  = '0;
                            footer_count = 3'(FOOTER_BYTES);
                            job_stage    = SC_PAYLOAD;
                            ev           = EV_HEADER;
                        end
                    end
                end
                SC_PAYLOAD: begin
                    ev          = EV_PIXEL;
                    pix         = b;
                    idx         = pixel_count[23:0];
                    pixel_count = pixel_count + 1'b1;
                    if (pixel_count >= pixel_total) begin
                        job_stage    = SC_FOOTER;
                        footer_count = 3'(FOOTER_BYTES);
                    end
                end
                SC_FOOTER: begin
                    if (footer_count > 0) footer_count = footer_count - 3'd1;
                    if (footer_count == 0) begin
                        job_stage = SC_DONE;
                        ev        = EV_JOB_DONE;
                    end else begin
                        ev = EV_IMG_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
        rs.event_res    = ev;
        rs.pixel_value  = pix;
        rs.pixel_index  = idx;
        rs.image_width  = job_width;
        rs.image_height = job_height;
        rs.copy_count   = job_copies;
        rs.stage        = job_stage;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_job();
            size_limit = MAX_IMAGE_RESET;
            expected_results.delete();
        end else begin
            // Follow writes of the limit register and check what reads return.
            if (psel && penable && pready && paddr == REG_MAX_IMAGE) begin
                if (pwrite) begin
                    size_limit = pwdata[LIMIT_W-1:0];
                end else if (prdata[LIMIT_W-1:0] !== size_limit) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS)
                        $display("Limit read back as %0d, expected %0d",
                                 prdata[LIMIT_W-1:0], size_limit);
                end
            end

            // Predict the result of every accepted request.
            if (i_in_valid && i_in_ready) begin
                parse_request(i_in_data, want);
                expected_results.push_back(want);
            end

            // Compare every accepted result with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS)
                        $display("Result with no request outstanding: ev=%0d stage=%0d",
                                 i_out_data.event_res, i_out_data.stage);
                end else begin
                    want = expected_results.pop_front();
                    case (want.event_res)
                        EV_PIXEL:    o_pixels++;
                        EV_HEADER:   o_headers++;
                        EV_ERROR:    o_errors++;
                        EV_JOB_DONE: o_jobs++;
                        default: begin
                        end
                    endcase
                    if (i_out_data.event_res    !== want.event_res    ||
                        i_out_data.pixel_value  !== want.pixel_value  ||
                        i_out_data.pixel_index  !== want.pixel_index  ||
                        i_out_data.image_width  !== want.image_width  ||
                        i_out_data.image_height !== want.image_height ||
                        i_out_data.copy_count   !== want.copy_count   ||
                        i_out_data.stage        !== want.stage) begin
                        o_mismatches++;
                        if (o_mismatches <= MAX_REPORTS)
                            $display({"Result %0d: expected ev=%0d px=%0d idx=%0d w=%0d h=%0d ",
                                      "copies=%0d stage=%0d, got ev=%0d px=%0d idx=%0d w=%0d ",
                                      "h=%0d copies=%0d stage=%0d"},
                                     o_results, want.event_res, want.pixel_value,
                                     want.pixel_index, want.image_width, want.image_height,
                                     want.copy_count, want.stage, i_out_data.event_res,
                                     i_out_data.pixel_value, i_out_data.pixel_index,
                                     i_out_data.image_width, i_out_data.image_height,
                                     i_out_data.copy_count, i_out_data.stage);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> sim/tb_print_job_stream_parser.sv
module tb_print_job_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import pjsp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int N_PHASES     = 4;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 4;
    // Smallest area of a header whose dimension bytes form the copy pattern.
    localparam int PAT_DIM_AREA = 512 * 2304;

    // Job marker text, CR LF at the end.
    localparam logic [8*MARK_LEN-1:0] JOB_MARKER = {
        8'h40, 8'h50, 8'h4A, 8'h4C, 8'h20, 8'h45, 8'h4E, 8'h54, 8'h45, 8'h52,
        8'h20, 8'h4C, 8'h41, 8'h4E, 8'h47, 8'h55, 8'h41, 8'h47, 8'h45, 8'h3D,
        8'h53, 8'h4F, 8'h4E, 8'h59, 8'h2D, 8'h50, 8'h44, 8'h4C, 8'h2D, 8'h44,
        8'h53, 8'h32, 8'h0D, 8'h0A
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    t_in_req     in_req;
    logic        out_valid;
    logic        out_ready;
    t_out_res    out_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results;
    int headers;
    int rejected;
    int jobs_done;
    int pixels;

    int cycle_count = 0;
    int items_sent  = 0;
    int send_quiet  = 0;
    int recv_quiet  = 0;

    // Requests of the job being sent, and its binary header.
    t_in_req    job_reqs[$];
    logic [7:0] hdr_buf[HEADER_BYTES];

    print_job_stream_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pjsp_checker #(
        .JOB_MARKER (JOB_MARKER)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_headers    (headers),
        .o_errors     (rejected),
        .o_jobs       (jobs_done),
        .o_pixels     (pixels)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Give up on a run that hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] marker_at(input int i);
        return JOB_MARKER[(MARK_LEN-1-i)*8 +: 8];
    endfunction

    // Random wait before an item, with occasional stretches of back-to-back items.
    task automatic pick_gap(inout int quiet, output int gap);
        if (quiet > 0) begin
            quiet--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            quiet = $urandom_range(16, 64);
            gap   = 0;
        end else begin
            gap = $urandom_range(0, 12);
        end
    endtask

    // Offers one request from a falling edge and returns at the falling edge
    // after it was taken, with valid still high.
    task automatic send_request(input t_in_req rq);
        int gap;
        pick_gap(send_quiet, gap);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_req   = rq;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic push_req(input logic op, input logic [7:0] b);
        job_reqs.push_back({op, b});
    endtask

    // Writes 02 00 09 at start, and the copy byte four places on if it fits.
    task automatic place_copy(input int start, input logic [7:0] copies);
        hdr_buf[start]     = COPY_PAT_0;
        hdr_buf[start + 1] = COPY_PAT_1;
        hdr_buf[start + 2] = COPY_PAT_2;
        if (start + 4 < HEADER_BYTES) hdr_buf[start + 4] = copies;
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = REG_MAX_IMAGE;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Stops offering and waits until every result has been taken.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: random stalls per result, and two long hold-offs that fill the block.
    initial begin
        int gap;
        int taken;
        taken     = 0;
        out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken == 300 || taken == 1000) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            pick_gap(recv_quiet, gap);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!out_valid);
            taken++;
            @(negedge i_clk);
        end
    end

    // Stimulus: directed marker cases, then whole jobs under several size limits.
    initial begin
        logic [LIMIT_W-1:0] limits[N_PHASES];
        logic [LIMIT_W-1:0] lim_now;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [31:0]        area;
        bit                 good;
        int                 phase;
        int                 phase_start;
        int                 jobs;
        int                 i;
        int                 plen;
        int                 cut;

        in_valid = 1'b0;
        in_req   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 1'b0;
        pwdata   = '0;
        jobs     = 0;

        limits[0] = MAX_IMAGE_RESET;
        limits[1] = 25'h1FFFFFF;
        limits[2] = 25'($urandom_range(1, 16777216));
        limits[3] = 25'($urandom_range(1, 30));
        lim_now   = MAX_IMAGE_RESET;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Prepare first, then byte extremes while scanning.
        send_request({OP_PREPARE, 8'hFF});
        send_request({OP_DATA, 8'h00});
        send_request({OP_DATA, 8'hFF});
        // A partial marker broken by '@', which restarts the match at one.
        for (i = 0; i < 3; i++) send_request({OP_DATA, marker_at(i)});
        send_request({OP_DATA, marker_at(0)});
        for (i = 1; i < 4; i++) send_request({OP_DATA, marker_at(i)});
        // A mismatch on another byte restarts at zero.
        send_request({OP_DATA, 8'h58});
        send_request({OP_DATA, marker_at(0)});
        send_request({OP_DATA, marker_at(0)});
        send_request({OP_DATA, marker_at(1)});
        // Prepare in mid-match clears the match.
        send_request({OP_PREPARE, marker_at(0)});
        send_request({OP_DATA, marker_at(2)});
        send_request({OP_DATA, 8'h0D});
        send_request({OP_DATA, 8'h0A});
        send_request({OP_PREPARE, 8'h00});

        for (phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                lim_now = limits[phase];
                apb_access(1'b1, {7'($urandom), lim_now});
                apb_access(1'b0, 32'h0);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                job_reqs.delete();

                // Noise, often with '@' and a partial marker, ahead of the marker.
                repeat ($urandom_range(0, 10))
                    push_req(OP_DATA, ($urandom_range(0, 2) == 0) ? marker_at(0) : 8'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    plen = $urandom_range(1, MARK_LEN - 1);
                    for (i = 0; i < plen; i++) push_req(OP_DATA, marker_at(i));
                    push_req(OP_DATA, ($urandom_range(0, 1) == 1) ? marker_at(0) : 8'($urandom));
                end
                for (i = 0; i < MARK_LEN; i++) push_req(OP_DATA, marker_at(i));

                // Dimensions: small images in half the jobs, zero in a quarter, far too large in a quarter.
                case (jobs % 4)
                    1: begin
                        if ($urandom_range(0, 1) == 1) begin
                            w = 16'd0;
                            h = 16'($urandom);
                        end else begin
                            w = 16'($urandom);
                            h = 16'd0;
                        end
                    end
                    2: begin
                        case ($urandom_range(0, 3))
                            0: begin
                                w = 16'hFFFF;
                                h = 16'hFFFF;
                            end
                            1: begin
                                if (lim_now < PAT_DIM_AREA) begin
                                    w = 16'h0200;
                                    h = {8'h09, 8'($urandom)};
                                end else begin
                                    w = 16'($urandom_range(16'h8000, 16'hFFFF));
                                    h = 16'($urandom_range(16'h0400, 16'hFFFF));
                                end
                            end
                            default: begin
                                w = 16'($urandom_range(16'h8000, 16'hFFFF));
                                h = 16'($urandom_range(16'h0400, 16'hFFFF));
                            end
                        endcase
                    end
                    default: begin
                        // Under a small limit, land on the limit or just past it.
                        if (lim_now < 36 && $urandom_range(0, 1) == 1) begin
                            w = 16'd1;
                            h = 16'(lim_now) + 16'($urandom_range(0, 1));
                        end else begin
                            w = 16'($urandom_range(1, 6));
                            h = 16'($urandom_range(1, 6));
                        end
                    end
                endcase

                // Header bytes with dimensions and copy patterns in various places.
                for (i = 0; i < HEADER_BYTES; i++) hdr_buf[i] = 8'($urandom);
                hdr_buf[WIDTH_OFFSET]      = w[15:8];
                hdr_buf[WIDTH_OFFSET + 1]  = w[7:0];
                hdr_buf[HEIGHT_OFFSET]     = h[15:8];
                hdr_buf[HEIGHT_OFFSET + 1] = h[7:0];
                case ($urandom_range(0, 5))
                    1: place_copy($urandom_range(4, 280), 8'($urandom));
                    2: place_copy(HEADER_BYTES - 5,
                                  ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom));
                    3: place_copy(HEADER_BYTES - 4 + $urandom_range(0, 1), 8'($urandom));
                    4: begin
                        place_copy($urandom_range(4, 140), 8'($urandom));
                        place_copy($urandom_range(150, 280), 8'($urandom));
                    end
                    5: place_copy($urandom_range(4, 280), 8'h00);
                    default: begin
                    end
                endcase
                for (i = 0; i < HEADER_BYTES; i++) push_req(OP_DATA, hdr_buf[i]);

                // Pixels and footer only when the header will be accepted.
                area = 32'(w) * 32'(h);
                good = (w != 0) && (h != 0) && (area <= 32'(lim_now));
                if (good) begin
                    repeat (area) push_req(OP_DATA, 8'($urandom));
                    repeat (FOOTER_BYTES) push_req(OP_DATA, 8'($urandom));
                end
                // Trailing bytes, dropped by the complete or error stage.
                repeat ($urandom_range(0, 4)) push_req(OP_DATA, 8'($urandom));

                // Now and then the job is cut short by the prepare.
                if ($urandom_range(0, 5) == 0) begin
                    cut = $urandom_range(1, job_reqs.size() - 1);
                    while (job_reqs.size() > cut) void'(job_reqs.pop_back());
                end
                push_req(OP_PREPARE, 8'($urandom));

                for (i = 0; i < job_reqs.size(); i++) send_request(job_reqs[i]);
                jobs++;
            end
        end

        wait_idle();
        $display("Sent %0d requests in %0d jobs under %0d size limits; %0d results checked.",
                 items_sent, jobs, N_PHASES, results);
        $display("Headers accepted %0d, rejected %0d; jobs completed %0d; pixel bytes %0d.",
                 headers, rejected, jobs_done, pixels);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule
